/* design/pptq_pkg.sv */
// Shared types and codes for the preemptive priority task queue.
// No dependencies; the datapath, controller and top level refer to it by scoped names.
package pptq_pkg;

  localparam int HANDLE_W = 64;
  localparam int ARG_W    = 64;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 6;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_DISPATCH = 2'd1;
  localparam logic [1:0] OP_FINISH   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IDLE = 3'd4;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [HANDLE_W-1:0] task_handle;
    logic [ARG_W-1:0]    task_arg;
    logic [PRIO_W-1:0]   task_priority;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] out_handle;
    logic [ARG_W-1:0]    out_arg;
    logic [PRIO_W-1:0]   out_priority;
    logic [COUNT_W-1:0]  queued_count;
    logic [COUNT_W-1:0]  nesting_depth;
  } out_t;

  // One queue slot as stored in the slot memory.
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [ARG_W-1:0]    arg;
    logic [PRIO_W-1:0]   prio;
  } slot_t;

  // Controller to datapath.
  typedef struct packed {
    logic                load;
    logic                scan_init;
    logic                scan_step;
    logic                put_new;
    logic                put_at_zero;
    logic                dsp_commit;
    logic                pop;
    logic                finish;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] opcode;
    logic       is_null;
    logic       full;
    logic       empty;
    logic       idle;
    logic       stack_full;
    logic       idx_zero;
    logic       rd_gt;
    logic       eligible;
  } stat_t;

endpackage

/* design/pptq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pptq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/pptq_datapath.sv */
// Datapath: sorted slot memory, priority nesting stack, counters and result register.
// Depends on pptq_pkg and pptq_ram.
module pptq_datapath #(
  parameter int TASK_SLOTS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  pptq_pkg::in_t    request,
  input  pptq_pkg::cmd_t   cmd,
  output pptq_pkg::stat_t  stat,
  output pptq_pkg::out_t   result,
  output logic             done
);

  localparam int IW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(TASK_SLOTS);

  pptq_pkg::in_t   item;
  pptq_pkg::slot_t new_slot;
  pptq_pkg::slot_t slot_rd;
  pptq_pkg::slot_t slot_wdata;
  logic [pptq_pkg::PRIO_W-1:0] stack_rd;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] depth;
  logic [CW-1:0] depth_next;
  logic [IW-1:0] idx;
  logic [IW-1:0] cnt_m1;
  logic [IW-1:0] dep_m1;
  logic [IW-1:0] slot_waddr;
  logic [IW-1:0] slot_raddr;
  logic          slot_we;

  logic [pptq_pkg::STATUS_W-1:0] status_q;
  logic [pptq_pkg::HANDLE_W-1:0] handle_q;
  logic [pptq_pkg::ARG_W-1:0]    arg_q;
  logic [pptq_pkg::PRIO_W-1:0]   prio_q;
  logic [CW+5:0]                 count_ext;
  logic [CW+5:0]                 depth_ext;

  assign cnt_m1 = IW'(count - CW'(1));
  assign dep_m1 = IW'(depth - CW'(1));

  assign new_slot.handle = item.task_handle;
  assign new_slot.arg    = item.task_arg;
  assign new_slot.prio   = item.task_priority;

  // Shift a higher entry up one place, or drop the new task into its slot.
  assign slot_we    = cmd.scan_step | cmd.put_new;
  assign slot_waddr = cmd.put_at_zero ? '0 : IW'(idx + IW'(1));
  assign slot_wdata = cmd.scan_step ? slot_rd : new_slot;
  assign slot_raddr = cmd.scan_step ? IW'(idx - IW'(1)) : cnt_m1;

  pptq_ram #(
    .WIDTH($bits(pptq_pkg::slot_t)),
    .DEPTH(TASK_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rd)
  );

  pptq_ram #(
    .WIDTH(pptq_pkg::PRIO_W),
    .DEPTH(TASK_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (cmd.dsp_commit),
    .waddr (depth[IW-1:0]),
    .wdata (slot_rd.prio),
    .raddr (dep_m1),
    .rdata (stack_rd)
  );

  always_comb begin
    count_next = count;
    depth_next = depth;
    if (cmd.put_new) begin
      count_next = count + CW'(1);
    end else if (cmd.dsp_commit) begin
      count_next = count - CW'(1);
    end
    if (cmd.dsp_commit) begin
      depth_next = depth + CW'(1);
    end else if (cmd.pop) begin
      depth_next = depth - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      depth <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      depth <= depth_next;
      done  <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= request;
    end
    if (cmd.scan_init) begin
      idx <= cnt_m1;
    end else if (cmd.scan_step) begin
      idx <= IW'(idx - IW'(1));
    end
    if (cmd.finish) begin
      status_q <= cmd.status;
      handle_q <= cmd.dsp_commit ? slot_rd.handle : '0;
      arg_q    <= cmd.dsp_commit ? slot_rd.arg : '0;
      prio_q   <= cmd.dsp_commit ? slot_rd.prio : '0;
    end
  end

  assign stat.opcode     = item.opcode;
  assign stat.is_null    = (item.task_handle == '0);
  assign stat.full       = (count == SLOTS_C);
  assign stat.empty      = (count == '0);
  assign stat.idle       = (depth == '0);
  assign stat.stack_full = (depth == SLOTS_C);
  assign stat.idx_zero   = (idx == '0);
  assign stat.rd_gt      = (slot_rd.prio > item.task_priority);
  assign stat.eligible   = (depth == '0) || (slot_rd.prio > stack_rd);

  // Counts only move at the final edge of a step, so the live values are
  // the after-step values while the strobe is up.
  assign count_ext = {6'd0, count};
  assign depth_ext = {6'd0, depth};

  assign result.status        = status_q;
  assign result.out_handle    = handle_q;
  assign result.out_arg       = arg_q;
  assign result.out_priority  = prio_q;
  assign result.queued_count  = count_ext[5:0];
  assign result.nesting_depth = depth_ext[5:0];

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= SLOTS_C) else $error("queued count beyond slot capacity");
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    depth <= SLOTS_C) else $error("nesting depth beyond stack capacity");
  a_commit_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.dsp_commit |-> (count != '0) && (depth != SLOTS_C))
    else $error("dispatch commit with empty queue or full stack");
  a_shift_holds_count: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |=> $stable(count)) else $error("count moved during shift");
`endif

endmodule

/* design/pptq_ctrl.sv */
// Controller state machine: decodes each command and sequences the datapath.
// Depends on pptq_pkg.
module pptq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pptq_pkg::stat_t stat,
  output pptq_pkg::cmd_t  cmd,
  output logic            busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_LAST   = 3'd3;
  localparam logic [2:0] S_DSP    = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.status = pptq_pkg::ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (stat.opcode)
          pptq_pkg::OP_ADD: begin
            priority if (stat.is_null) begin
              cmd.finish = 1'b1;
              cmd.status = pptq_pkg::ST_NULL;
            end else if (stat.full) begin
              cmd.finish = 1'b1;
              cmd.status = pptq_pkg::ST_FULL;
            end else if (stat.empty) begin
              cmd.put_new     = 1'b1;
              cmd.put_at_zero = 1'b1;
              cmd.finish      = 1'b1;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
          pptq_pkg::OP_DISPATCH: begin
            if (stat.empty || stat.stack_full) begin
              cmd.finish = 1'b1;
              cmd.status = pptq_pkg::ST_NONE;
            end else begin
              state_next = S_DSP;
            end
          end
          pptq_pkg::OP_FINISH: begin
            cmd.finish = 1'b1;
            if (stat.idle) begin
              cmd.status = pptq_pkg::ST_IDLE;
            end else begin
              cmd.pop = 1'b1;
            end
          end
          default: begin
            cmd.finish = 1'b1;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.rd_gt) begin
          cmd.scan_step = 1'b1;
          if (stat.idx_zero) begin
            state_next = S_LAST;
          end
        end else begin
          cmd.put_new = 1'b1;
          cmd.finish  = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_LAST: begin
        cmd.put_new     = 1'b1;
        cmd.put_at_zero = 1'b1;
        cmd.finish      = 1'b1;
        state_next      = S_IDLE;
      end
      S_DSP: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
        if (stat.eligible) begin
          cmd.dsp_commit = 1'b1;
        end else begin
          cmd.status = pptq_pkg::ST_NONE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/preemptive_priority_task_queue.sv */
// Top level of the preemptive priority task queue.
// Depends on pptq_pkg, pptq_ctrl, pptq_datapath (and pptq_ram below it).
//
// Usage:
//   Request channel: drive request and raise start; the beat is taken at the
//   rising edge where start is high and busy is low. Busy stays high until
//   the step is done.
//   Result channel: done is high for exactly one cycle with the result on
//   result; the receiver cannot stall, so sample it in that cycle. busy is
//   already low in the done cycle, so the next beat may be issued there.
//   Each step: finish, unused opcode, rejected add and add to an empty queue
//     finish in the decode state; a dispatch reads the slot and stack
//     memories, then compares in the dispatch state; an add to a non-empty
//     queue moves each queued task of strictly higher priority up one
//     slot per cycle through the single-port-write slot memory, then
//     writes the new task into the freed slot.
//   queued_count and nesting_depth in the result are the counts after the
//   step. Reset (synchronous) empties the queue and the nesting stack; no
//   clearing pass is needed since only entries below the counts are read.
//   Slots are held in ascending priority, the top entry leaves on dispatch,
//   and a dispatch only wins if its priority beats the running priority.
module preemptive_priority_task_queue #(
  parameter int TASK_SLOTS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pptq_pkg::in_t  request,
  output logic           done,
  output pptq_pkg::out_t result
);

  pptq_pkg::cmd_t  cmd;
  pptq_pkg::stat_t stat;

  // Sequence each step: decode, then shift or compare as the command needs.
  pptq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold slots, stack, counters; register the result beat.
  pptq_datapath #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result),
    .done    (done)
  );

endmodule
